// ===== src/mecanum_wheel_kinematics_assert.svh =====
// Assertion macros for the mecanum wheel kinematics block.
`ifndef MECANUM_WHEEL_KINEMATICS_ASSERT_SVH
`define MECANUM_WHEEL_KINEMATICS_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define MWK_ASSERT_NOW(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
        else $error("mwk assertion failed");

// Next-cycle implication, checked out of reset.
`define MWK_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
        else $error("mwk assertion failed");

`endif

// ===== src/mwk_pkg.sv =====
`timescale 1ns / 1ps

package mwk_pkg;

    localparam int TRIG_FRACTION_BITS = 15;
    localparam int TRIG_W   = TRIG_FRACTION_BITS + 1;
    localparam int TRIG_S_W = TRIG_W + 1;
    localparam int SPD_W    = 8;
    localparam int PWM_W    = 8;
    localparam int VEL_W    = SPD_W + TRIG_W + 1;
    localparam int PROD_W   = SPD_W + 1 + TRIG_S_W;
    localparam int SUM_W    = VEL_W + 1;
    localparam int MAG_W    = SUM_W - TRIG_FRACTION_BITS;
    localparam int ROM_DEPTH = 91;
    localparam int ROM_AW    = 7;

    localparam logic [63:0] Q30_PI = 64'd3373259426;

    localparam logic [1:0] DIR_STOP = 2'd0;
    localparam logic [1:0] DIR_FWD  = 2'd1;
    localparam logic [1:0] DIR_REV  = 2'd2;

    localparam logic [1:0] CLAMP_NONE = 2'd0;
    localparam logic [1:0] CLAMP_MAX  = 2'd1;
    localparam logic [1:0] CLAMP_NEG  = 2'd2;

    localparam logic [SPD_W-1:0] SPEED_LIMIT_RST = 8'd100;

    typedef struct packed {
        logic signed [15:0] drive_speed;
        logic signed [15:0] heading_deg;
    } t_cmd;

    typedef struct packed {
        logic [PWM_W-1:0] wheel1_pwm;
        logic [PWM_W-1:0] wheel2_pwm;
        logic [PWM_W-1:0] wheel3_pwm;
        logic [PWM_W-1:0] wheel4_pwm;
        logic [1:0]       wheel1_dir;
        logic [1:0]       wheel2_dir;
        logic [1:0]       wheel3_dir;
        logic [1:0]       wheel4_dir;
        logic [1:0]       speed_clamp_status;
        logic [3:0]       range_error_bits;
    } t_result;

    // Drive for a wheel sum and for its negation (same magnitude).
    typedef struct packed {
        logic [PWM_W-1:0] pwm;
        logic [1:0]       dir_pos;
        logic [1:0]       dir_neg;
        logic             err;
    } t_wheel_drv;

    typedef logic [TRIG_W-1:0] t_sin_rom [0:ROM_DEPTH-1];

    // sin(k deg), k = 0..90: Q30 Taylor series through x^17, rounded to
    // TRIG_FRACTION_BITS. Evaluated at elaboration only.
    function automatic t_sin_rom f_sin_rom();
        t_sin_rom    rom;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        longint      sum;
        for (int k = 0; k < ROM_DEPTH; k++) begin
            x    = (64'(k) * Q30_PI + 64'd90) / 64'd180;
            x2   = (x * x) >> 30;
            term = x;
            sum  = longint'(x);
            for (int n = 1; n <= 8; n++) begin
                term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
                if (n % 2 == 1) begin
                    sum = sum - longint'(term);
                end else begin
                    sum = sum + longint'(term);
                end
            end
            if (sum < 0) begin
                sum = 0;
            end
            if (sum > (longint'(1) << 30)) begin
                sum = longint'(1) << 30;
            end
            rom[k] = TRIG_W'((sum + (longint'(1) << (29 - TRIG_FRACTION_BITS)))
                             >>> (30 - TRIG_FRACTION_BITS));
        end
        return rom;
    endfunction

    localparam t_sin_rom SIN_ROM = f_sin_rom();

endpackage

// ===== src/mwk_wheel_out.sv =====
`timescale 1ns / 1ps

module mwk_wheel_out (
    input  logic signed [mwk_pkg::SUM_W-1:0] i_sum,
    output mwk_pkg::t_wheel_drv              o_drv
);
    import mwk_pkg::*;

    logic             w_neg;
    logic [SUM_W-1:0] w_abs;
    logic [MAG_W-1:0] w_mag;
    logic             w_over;

    assign w_neg  = i_sum[SUM_W-1];
    assign w_abs  = w_neg ? -i_sum : i_sum;
    assign w_mag  = w_abs[SUM_W-1:TRIG_FRACTION_BITS];
    assign w_over = |w_mag[MAG_W-1:PWM_W];

    always_comb begin
        o_drv.err = w_over;
        o_drv.pwm = w_over ? '0 : w_mag[PWM_W-1:0];
        if (w_mag == '0) begin
            o_drv.dir_pos = DIR_STOP;
            o_drv.dir_neg = DIR_STOP;
        end else if (w_neg) begin
            o_drv.dir_pos = DIR_REV;
            o_drv.dir_neg = DIR_FWD;
        end else begin
            o_drv.dir_pos = DIR_FWD;
            o_drv.dir_neg = DIR_REV;
        end
    end

endmodule

// ===== src/mecanum_wheel_kinematics.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Handshake            Payload
// command   in         i_valid / o_ready    i_cmd    (t_cmd)
// result    out        o_valid / i_ready    o_result (t_result)
// config    in         i_cfg_wr_en          i_cfg_wr_data (speed limit)
//
// One transaction per cycle sustained while i_ready is high; six register stages.
// Stages: input, clamp and heading reciprocal multiply, mod 360, trig table,
// velocity multiply, wheel outputs. Each stage holds while the next is full
// and stalled, so empty stages still fill while a result waits.
// Synchronous active-low reset empties the pipeline and sets the speed limit to 100.
`include "mecanum_wheel_kinematics_assert.svh"

module mecanum_wheel_kinematics (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  mwk_pkg::t_cmd          i_cmd,
    output logic                   o_valid,
    input  logic                   i_ready,
    output mwk_pkg::t_result       o_result,
    input  logic                   i_cfg_wr_en,
    input  logic [mwk_pkg::SPD_W-1:0] i_cfg_wr_data
);
    import mwk_pkg::*;

    localparam int          NSTG        = 6;
    localparam logic [16:0] HDG_OFFSET  = 17'd33120;   // 92 * 360
    localparam logic [16:0] HDG_RECIP   = 17'd93207;   // ceil(2^25 / 360)
    localparam int          HDG_SHIFT   = 25;
    localparam logic [16:0] DEG_360     = 17'd360;
    localparam logic [8:0]  DEG_90      = 9'd90;
    localparam logic [8:0]  DEG_180     = 9'd180;
    localparam logic [8:0]  DEG_270     = 9'd270;
    localparam logic [ROM_AW-1:0] IDX_90 = 7'd90;

    logic [SPD_W-1:0] r_speed_limit;
    logic [NSTG-1:0]  r_vld;
    logic [NSTG-1:0]  w_rdy;

    // stage 0
    t_cmd r_cmd;
    // stage 1
    logic [SPD_W-1:0] r_spd1, n_spd1;
    logic [1:0]       r_stat1, n_stat1;
    logic [16:0]      r_u1, n_u1;
    logic [7:0]       r_q1;
    logic [33:0]      w_qprod;
    // stage 2
    logic [SPD_W-1:0] r_spd2;
    logic [1:0]       r_stat2;
    logic [8:0]       r_h2;
    logic [16:0]      w_q360;
    // stage 3
    logic [SPD_W-1:0]          r_spd3;
    logic [1:0]                r_stat3;
    logic signed [TRIG_S_W-1:0] r_sin3, n_sin3, r_cos3, n_cos3;
    logic [1:0]                w_quad;
    logic [ROM_AW-1:0]         w_ridx;
    logic signed [TRIG_S_W-1:0] w_ta, w_tb;
    // stage 4
    logic [1:0]                r_stat4;
    logic signed [VEL_W-1:0]   r_vx4, r_vy4;
    logic signed [PROD_W-1:0]  w_px, w_py;
    // stage 5
    t_result                   r_res, n_res;
    logic signed [SUM_W-1:0]   w_sum_d, w_sum_s;
    t_wheel_drv                w_drv_d, w_drv_s;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed_limit <= SPEED_LIMIT_RST;
        end else if (i_cfg_wr_en) begin
            r_speed_limit <= i_cfg_wr_data;
        end
    end

    always_comb begin
        w_rdy[NSTG-1] = !r_vld[NSTG-1] || i_ready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            w_rdy[k] = !r_vld[k] || w_rdy[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_rdy[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (w_rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // stage 1: speed clamp, heading offset and reciprocal multiply
    always_comb begin
        if (r_cmd.drive_speed > $signed({8'd0, r_speed_limit})) begin
            n_spd1  = r_speed_limit;
            n_stat1 = CLAMP_MAX;
        end else if (r_cmd.drive_speed[15]) begin
            n_spd1  = '0;
            n_stat1 = CLAMP_NEG;
        end else begin
            n_spd1  = r_cmd.drive_speed[SPD_W-1:0];
            n_stat1 = CLAMP_NONE;
        end
        n_u1 = {r_cmd.heading_deg[15], r_cmd.heading_deg} + HDG_OFFSET;
    end

    assign w_qprod = n_u1 * HDG_RECIP;

    // stage 2: heading mod 360
    assign w_q360 = {9'd0, r_q1} * DEG_360;

    // stage 3: quadrant split and sine/cosine lookup
    always_comb begin
        if (r_h2 >= DEG_270) begin
            w_quad = 2'd3;
            w_ridx = ROM_AW'(r_h2 - DEG_270);
        end else if (r_h2 >= DEG_180) begin
            w_quad = 2'd2;
            w_ridx = ROM_AW'(r_h2 - DEG_180);
        end else if (r_h2 >= DEG_90) begin
            w_quad = 2'd1;
            w_ridx = ROM_AW'(r_h2 - DEG_90);
        end else begin
            w_quad = 2'd0;
            w_ridx = ROM_AW'(r_h2);
        end
        w_ta = $signed({1'b0, SIN_ROM[w_ridx]});
        w_tb = $signed({1'b0, SIN_ROM[IDX_90 - w_ridx]});
        case (w_quad)
            2'd0: begin
                n_sin3 = w_ta;
                n_cos3 = w_tb;
            end
            2'd1: begin
                n_sin3 = w_tb;
                n_cos3 = -w_ta;
            end
            2'd2: begin
                n_sin3 = -w_ta;
                n_cos3 = -w_tb;
            end
            default: begin
                n_sin3 = -w_tb;
                n_cos3 = w_ta;
            end
        endcase
    end

    // stage 4: velocity components
    assign w_px = $signed({1'b0, r_spd3}) * r_cos3;
    assign w_py = $signed({1'b0, r_spd3}) * r_sin3;

    // stage 5: wheel sums; w2 = -w3 and w4 = -w1
    assign w_sum_d = {r_vx4[VEL_W-1], r_vx4} - {r_vy4[VEL_W-1], r_vy4};
    assign w_sum_s = {r_vx4[VEL_W-1], r_vx4} + {r_vy4[VEL_W-1], r_vy4};

    mwk_wheel_out u_wheel_diff (
        .i_sum (w_sum_d),
        .o_drv (w_drv_d)
    );

    mwk_wheel_out u_wheel_sum (
        .i_sum (w_sum_s),
        .o_drv (w_drv_s)
    );

    always_comb begin
        n_res.wheel1_pwm         = w_drv_d.pwm;
        n_res.wheel2_pwm         = w_drv_s.pwm;
        n_res.wheel3_pwm         = w_drv_s.pwm;
        n_res.wheel4_pwm         = w_drv_d.pwm;
        n_res.wheel1_dir         = w_drv_d.dir_pos;
        n_res.wheel2_dir         = w_drv_s.dir_neg;
        n_res.wheel3_dir         = w_drv_s.dir_pos;
        n_res.wheel4_dir         = w_drv_d.dir_neg;
        n_res.speed_clamp_status = r_stat4;
        n_res.range_error_bits   = {w_drv_d.err, w_drv_s.err, w_drv_s.err, w_drv_d.err};
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r_cmd <= i_cmd;
        end
        if (w_rdy[1]) begin
            r_spd1  <= n_spd1;
            r_stat1 <= n_stat1;
            r_u1    <= n_u1;
            r_q1    <= w_qprod[HDG_SHIFT+7:HDG_SHIFT];
        end
        if (w_rdy[2]) begin
            r_spd2  <= r_spd1;
            r_stat2 <= r_stat1;
            r_h2    <= 9'(r_u1 - w_q360);
        end
        if (w_rdy[3]) begin
            r_spd3  <= r_spd2;
            r_stat3 <= r_stat2;
            r_sin3  <= n_sin3;
            r_cos3  <= n_cos3;
        end
        if (w_rdy[4]) begin
            r_stat4 <= r_stat3;
            r_vx4   <= w_px[VEL_W-1:0];
            r_vy4   <= w_py[VEL_W-1:0];
        end
        if (w_rdy[5]) begin
            r_res <= n_res;
        end
    end

    assign o_ready  = w_rdy[0];
    assign o_valid  = r_vld[NSTG-1];
    assign o_result = r_res;

    `MWK_ASSERT_NOW(a_stop_no_pwm, i_clk, i_rst_n,
        o_valid && o_result.wheel1_dir == DIR_STOP,
        o_result.wheel1_pwm == '0 && !o_result.range_error_bits[0])
    `MWK_ASSERT_NOW(a_pair_match, i_clk, i_rst_n, o_valid,
        o_result.wheel1_pwm == o_result.wheel4_pwm &&
        o_result.range_error_bits[0] == o_result.range_error_bits[3])
    `MWK_ASSERT_NOW(a_neg_speed_idle, i_clk, i_rst_n,
        o_valid && o_result.speed_clamp_status == CLAMP_NEG,
        o_result.range_error_bits == '0 && o_result.wheel3_dir == DIR_STOP)
    `MWK_ASSERT_NEXT(a_full_stall, i_clk, i_rst_n,
        !o_ready && !i_ready, o_valid && !o_ready == !i_ready)

endmodule

// ===== tb/mecanum_wheel_kinematics_tb.sv =====
`timescale 1ns / 1ps

module mecanum_wheel_kinematics_tb;
    import mwk_pkg::*;

    localparam int          FRAC_BITS   = TRIG_FRACTION_BITS;
    localparam logic [63:0] PI_Q30      = 64'd3373259426;
    localparam int          PWM_MAX     = (1 << PWM_W) - 1;
    localparam int          LATENCY     = 6;
    localparam int          CYCLE_LIMIT = 400000;
    localparam int          MAX_SHOWN   = 10;
    localparam int          PHASE_ITEMS = 178;

    typedef struct {
        t_cmd    cmd;
        t_result res;
    } t_wheel_expect;

    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             cmd_valid   = 1'b0;
    t_cmd             cmd_data    = '0;
    logic             res_ready   = 1'b0;
    logic             cfg_wr_en   = 1'b0;
    logic [SPD_W-1:0] cfg_wr_data = '0;
    logic             o_ready;
    logic             o_valid;
    t_result          o_result;

    t_wheel_expect    pending_wheels_q[$];
    int               speed_limit_cfg = 100;
    int               mismatch_count  = 0;
    int               stall_left      = 0;
    int               cycle_count     = 0;
    bit               send_idle_on    = 1'b1;
    bit               recv_idle_on    = 1'b1;

    mecanum_wheel_kinematics DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (cmd_valid),
        .o_ready       (o_ready),
        .i_cmd         (cmd_data),
        .o_valid       (o_valid),
        .i_ready       (res_ready),
        .o_result      (o_result),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data)
    );

    always #5 i_clk = ~i_clk;

    // sin(k deg) in Q(FRAC_BITS): Q30 Taylor series through x^17, rounded half up
    function automatic longint sine_deg_q(input int k);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        longint      acc;
        x    = (64'(k) * PI_Q30 + 64'd90) / 64'd180;
        x2   = (x * x) >> 30;
        term = x;
        acc  = longint'(x);
        for (int n = 1; n <= 8; n++) begin
            term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
            if (n % 2 == 1) begin
                acc = acc - longint'(term);
            end else begin
                acc = acc + longint'(term);
            end
        end
        if (acc < 0) begin
            acc = 0;
        end
        if (acc > (longint'(1) << 30)) begin
            acc = longint'(1) << 30;
        end
        return (acc + (longint'(1) << (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
    endfunction

    function automatic void wheel_drive(input longint w, output logic [PWM_W-1:0] pwm,
                                        output logic [1:0] dir, output logic over);
        longint mag;
        mag  = (w < 0 ? -w : w) >>> FRAC_BITS;
        dir  = (mag == 0) ? DIR_STOP : ((w < 0) ? DIR_REV : DIR_FWD);
        over = (mag > PWM_MAX);
        pwm  = over ? '0 : PWM_W'(mag);
    endfunction

    function automatic t_result predict_wheel_drive(input t_cmd c);
        t_result r;
        int      spd;
        int      hdg;
        int      rem;
        longint  sn;
        longint  cs;
        longint  vx;
        longint  vy;
        logic    e1, e2, e3, e4;
        r   = '0;
        spd = int'(c.drive_speed);
        r.speed_clamp_status = CLAMP_NONE;
        if (spd > speed_limit_cfg) begin
            spd = speed_limit_cfg;
            r.speed_clamp_status = CLAMP_MAX;
        end else if (spd < 0) begin
            spd = 0;
            r.speed_clamp_status = CLAMP_NEG;
        end
        hdg = int'(c.heading_deg) % 360;
        if (hdg < 0) begin
            hdg = hdg + 360;
        end
        rem = hdg % 90;
        case (hdg / 90)
            0: begin
                sn = sine_deg_q(rem);
                cs = sine_deg_q(90 - rem);
            end
            1: begin
                sn = sine_deg_q(90 - rem);
                cs = -sine_deg_q(rem);
            end
            2: begin
                sn = -sine_deg_q(rem);
                cs = -sine_deg_q(90 - rem);
            end
            default: begin
                sn = -sine_deg_q(90 - rem);
                cs = sine_deg_q(rem);
            end
        endcase
        vx = longint'(spd) * cs;
        vy = longint'(spd) * sn;
        wheel_drive(vx - vy,    r.wheel1_pwm, r.wheel1_dir, e1);
        wheel_drive(-(vx + vy), r.wheel2_pwm, r.wheel2_dir, e2);
        wheel_drive(vx + vy,    r.wheel3_pwm, r.wheel3_dir, e3);
        wheel_drive(vy - vx,    r.wheel4_pwm, r.wheel4_dir, e4);
        r.range_error_bits = {e4, e3, e2, e1};
        return r;
    endfunction

    task automatic check_field(input string name, input int expv, input int actv,
                               input t_cmd c);
        if (expv != actv) begin
            mismatch_count++;
            if (mismatch_count <= MAX_SHOWN) begin
                $display("%0t: %s mismatch, speed %0d heading %0d: expected %0d, got %0d",
                         $time, name, c.drive_speed, c.heading_deg, expv, actv);
            end
        end
    endtask

    // result side: check each transaction, then draw a stall
    always @(posedge i_clk) begin : result_check
        t_wheel_expect exp_item;
        int            stall;
        if (!i_rst_n) begin
            res_ready <= 1'b0;
            stall_left = 0;
        end else if (o_valid && res_ready) begin
            if (pending_wheels_q.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_SHOWN) begin
                    $display("%0t: result with nothing expected", $time);
                end
            end else begin
                exp_item = pending_wheels_q.pop_front();
                check_field("wheel1_pwm", exp_item.res.wheel1_pwm, o_result.wheel1_pwm,
                            exp_item.cmd);
                check_field("wheel2_pwm", exp_item.res.wheel2_pwm, o_result.wheel2_pwm,
                            exp_item.cmd);
                check_field("wheel3_pwm", exp_item.res.wheel3_pwm, o_result.wheel3_pwm,
                            exp_item.cmd);
                check_field("wheel4_pwm", exp_item.res.wheel4_pwm, o_result.wheel4_pwm,
                            exp_item.cmd);
                check_field("wheel1_dir", exp_item.res.wheel1_dir, o_result.wheel1_dir,
                            exp_item.cmd);
                check_field("wheel2_dir", exp_item.res.wheel2_dir, o_result.wheel2_dir,
                            exp_item.cmd);
                check_field("wheel3_dir", exp_item.res.wheel3_dir, o_result.wheel3_dir,
                            exp_item.cmd);
                check_field("wheel4_dir", exp_item.res.wheel4_dir, o_result.wheel4_dir,
                            exp_item.cmd);
                check_field("speed_clamp_status", exp_item.res.speed_clamp_status,
                            o_result.speed_clamp_status, exp_item.cmd);
                check_field("range_error_bits", exp_item.res.range_error_bits,
                            o_result.range_error_bits, exp_item.cmd);
            end
            stall = recv_idle_on ? $urandom_range(0, 10) : 0;
            if (stall == 0) begin
                res_ready <= 1'b1;
            end else begin
                res_ready <= 1'b0;
                stall_left = stall;
            end
        end else if (!res_ready) begin
            if (stall_left <= 1) begin
                res_ready <= 1'b1;
                stall_left = 0;
            end else begin
                stall_left = stall_left - 1;
            end
        end
    end

    task automatic send_cmd(input int spd, input int hdg);
        t_cmd          c;
        t_wheel_expect item;
        int            gap;
        c.drive_speed = 16'(spd);
        c.heading_deg = 16'(hdg);
        gap = send_idle_on ? $urandom_range(0, 10) : 0;
        if (gap != 0) begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cmd_valid <= 1'b1;
        cmd_data  <= c;
        do @(posedge i_clk); while (!o_ready);
        item.cmd = c;
        item.res = predict_wheel_drive(c);
        pending_wheels_q.push_back(item);
    endtask

    task automatic drain_pipeline();
        cmd_valid <= 1'b0;
        while (pending_wheels_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 2) @(posedge i_clk);
    endtask

    task automatic write_speed_limit(input int value);
        drain_pipeline();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= SPD_W'(value);
        @(posedge i_clk);
        cfg_wr_en     <= 1'b0;
        speed_limit_cfg = value;
    endtask

    // reset value of the speed limit, speed and heading extremes, all quadrants
    task automatic test_reset_default_clamp();
        int spd_list[14] = '{0, 100, 101, 32767, -1, -32768, 50, 100, 100, 100, 77, 100,
                             100, 60};
        int hdg_list[14] = '{0, 0, 90, 180, 270, 45, 359, 360, -1, -90, 32767, -32768,
                             135, -315};
        for (int i = 0; i < 14; i++) begin
            send_cmd(spd_list[i], hdg_list[i]);
        end
    endtask

    // zero clamp, then full scale where diagonal headings overrange
    task automatic test_config_extremes();
        write_speed_limit(0);
        send_cmd(-5, 30);
        send_cmd(0, 200);
        send_cmd(5, 300);
        write_speed_limit(255);
        send_cmd(255, 45);
        send_cmd(255, 135);
        send_cmd(255, 225);
        send_cmd(255, 315);
        send_cmd(255, 0);
        send_cmd(200, 90);
    endtask

    task automatic test_random_settings();
        int settings[9];
        int spd;
        int hdg;
        int sel;
        settings = '{0, 1, 255, 254, 100, 180, 0, 0, 0};
        for (int p = 6; p < 9; p++) begin
            settings[p] = $urandom_range(0, 255);
        end
        for (int p = 0; p < 9; p++) begin
            write_speed_limit(settings[p]);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n % 40 == 0) begin
                    send_idle_on = ($urandom_range(0, 3) != 0);
                    recv_idle_on = ($urandom_range(0, 3) != 0);
                end
                if (p == 3 && n == PHASE_ITEMS / 2) begin
                    drain_pipeline();
                end
                sel = $urandom_range(0, 99);
                if (sel < 60) begin
                    spd = $urandom_range(0, speed_limit_cfg + 2);
                end else if (sel < 75) begin
                    spd = -int'($urandom_range(1, 32768));
                end else begin
                    spd = int'(16'($urandom));
                end
                sel = $urandom_range(0, 99);
                if (sel < 50) begin
                    hdg = $urandom_range(0, 359);
                end else if (sel < 70) begin
                    hdg = (int'($urandom_range(0, 16)) - 8) * 90
                          + int'($urandom_range(0, 2)) - 1;
                end else begin
                    hdg = int'(16'($urandom));
                end
                send_cmd(spd, hdg);
            end
        end
    endtask

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_default_clamp();
        test_config_extremes();
        test_random_settings();
        drain_pipeline();
        repeat (20) @(posedge i_clk);
        if (pending_wheels_q.size() != 0) begin
            mismatch_count += pending_wheels_q.size();
        end
        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
